[rtl/gtrd_pkg.sv]
// Shared types and constants for the grid tile rectangle diff block.
// Used by the configuration, controller, datapath and top-level modules.
package gtrd_pkg;

    // Default grid limits, handed to the top-level parameters.
    localparam int DEF_MAX_COLS = 8;
    localparam int DEF_MAX_ROWS = 8;

    // Field widths fixed by the interface.
    localparam int OP_W     = 2;
    localparam int EDGE_W   = 16;
    localparam int OLD_W    = 8;
    localparam int TILE_W   = 6;
    localparam int ACT_W    = 2;
    localparam int STORE_W  = 3;
    localparam int CFG_W    = 4;

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_COL_COUNT = 1'b0;
    localparam logic REG_ROW_COUNT = 1'b1;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd4;

    // At most this many results leave for one request.
    localparam int RESULT_CAP = 64;
    localparam int CAP_W      = $clog2(RESULT_CAP + 1);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_CREATE   = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE   = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE   = 2'd2;
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    // Per-tile action codes.
    localparam logic [ACT_W-1:0] ACT_CREATED = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETED = 2'd1;
    localparam logic [ACT_W-1:0] ACT_UPDATED = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic capture;
        logic advance;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic none;
        logic slot_free;
        logic done_evt;
    } status_t;

endpackage

[rtl/gtrd_cfg.sv]
// Configuration register file: column and row counts behind an APB-style port.
// Depends on gtrd_pkg.
module gtrd_cfg
    import gtrd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [CFG_W-1:0]      col_count,
    output logic [CFG_W-1:0]      row_count
);

    logic [CFG_W-1:0] col_count_reg;
    logic [CFG_W-1:0] row_count_reg;
    logic             wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= CFG_RESET;
            row_count_reg <= CFG_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_COL_COUNT)
            begin
                col_count_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                row_count_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_ROW_COUNT) ? APB_DATA_W'(row_count_reg)
                                                 : APB_DATA_W'(col_count_reg);
    assign col_count = col_count_reg;
    assign row_count = row_count_reg;

endmodule

[rtl/gtrd_ctrl.sv]
// Sequencing state machine: takes a request, then steps the tile scan.
// Depends on gtrd_pkg.
module gtrd_ctrl
    import gtrd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output cmd_t    cmd,
    input  status_t sts
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.advance = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid && !sts.none)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.advance = sts.slot_free;
                if (sts.done_evt)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/gtrd_dp.sv]
// Datapath: maps bounds to tile rectangles, scans tiles and holds the result register.
// Depends on gtrd_pkg; driven by gtrd_ctrl.
module gtrd_dp
    import gtrd_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output status_t             sts,
    input  logic [CFG_W-1:0]    col_count,
    input  logic [CFG_W-1:0]    row_count,
    input  logic [OP_W-1:0]     op,
    input  logic [EDGE_W-1:0]   left_x,
    input  logic [EDGE_W-1:0]   top_y,
    input  logic [EDGE_W-1:0]   right_x,
    input  logic [EDGE_W-1:0]   bottom_y,
    input  logic [OLD_W-1:0]    old_col_lo,
    input  logic [OLD_W-1:0]    old_row_lo,
    input  logic [OLD_W-1:0]    old_col_hi,
    input  logic [OLD_W-1:0]    old_row_hi,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [TILE_W-1:0]   tile_index,
    output logic [ACT_W-1:0]    action,
    output logic                last,
    output logic [STORE_W-1:0]  new_col_lo,
    output logic [STORE_W-1:0]  new_row_lo,
    output logic [STORE_W-1:0]  new_col_hi,
    output logic [STORE_W-1:0]  new_row_hi
);

    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CCNT_W = $clog2(MAX_COLS + 1);
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);
    localparam int CPROD_W = EDGE_W + CCNT_W;
    localparam int RPROD_W = EDGE_W + RCNT_W;

    // Effective grid size and tile rectangles of the offered request.
    logic [CCNT_W-1:0]  cols;
    logic [RCNT_W-1:0]  rows;
    logic [COL_W-1:0]   cols_m1;
    logic [ROW_W-1:0]   rows_m1;
    logic [CPROD_W-1:0] prod_l, prod_r;
    logic [RPROD_W-1:0] prod_t, prod_b;
    logic [COL_W-1:0]   nc0, nc1, oc0, oc1, lc;
    logic [ROW_W-1:0]   nr0, nr1, or0, or1, lr;
    logic               new_ok, old_ok, new_after, has_evt;

    // Captured request.
    logic [OP_W-1:0]    op_reg;
    logic [COL_W-1:0]   nc0_reg, nc1_reg, oc0_reg, oc1_reg, last_col_reg, cols_m1_reg;
    logic [ROW_W-1:0]   nr0_reg, nr1_reg, or0_reg, or1_reg, last_row_reg;

    // Scan position.
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [TILE_W-1:0]  tile_reg, tile_next;
    logic [CAP_W-1:0]   cnt_reg, cnt_next;

    logic               in_new, in_old, evt, at_last, cap_hit, is_last;
    logic [ACT_W-1:0]   act;
    logic               out_valid_reg, out_valid_next;
    logic               load_out;

    logic [TILE_W-1:0]  tile_index_reg;
    logic [ACT_W-1:0]   action_reg;
    logic               last_reg;
    logic [STORE_W-1:0] new_col_lo_reg, new_row_lo_reg, new_col_hi_reg, new_row_hi_reg;

    // A zero count behaves as one; counts past the grid limit saturate.
    always_comb
    begin
        if (col_count == '0)
        begin
            cols = CCNT_W'(1);
        end
        else if (int'(col_count) > MAX_COLS)
        begin
            cols = CCNT_W'(MAX_COLS);
        end
        else
        begin
            cols = CCNT_W'(col_count);
        end
        if (row_count == '0)
        begin
            rows = RCNT_W'(1);
        end
        else if (int'(row_count) > MAX_ROWS)
        begin
            rows = RCNT_W'(MAX_ROWS);
        end
        else
        begin
            rows = RCNT_W'(row_count);
        end
    end

    assign cols_m1 = COL_W'(cols - CCNT_W'(1));
    assign rows_m1 = ROW_W'(rows - RCNT_W'(1));

    // floor(q * n / 65536) is always below n, so no clamp is needed here.
    assign prod_l = CPROD_W'(left_x)   * CPROD_W'(cols);
    assign prod_r = CPROD_W'(right_x)  * CPROD_W'(cols);
    assign prod_t = RPROD_W'(top_y)    * RPROD_W'(rows);
    assign prod_b = RPROD_W'(bottom_y) * RPROD_W'(rows);
    assign nc0 = COL_W'(prod_l >> EDGE_W);
    assign nc1 = COL_W'(prod_r >> EDGE_W);
    assign nr0 = ROW_W'(prod_t >> EDGE_W);
    assign nr1 = ROW_W'(prod_b >> EDGE_W);

    assign oc0 = (old_col_lo > OLD_W'(cols_m1)) ? cols_m1 : COL_W'(old_col_lo);
    assign oc1 = (old_col_hi > OLD_W'(cols_m1)) ? cols_m1 : COL_W'(old_col_hi);
    assign or0 = (old_row_lo > OLD_W'(rows_m1)) ? rows_m1 : ROW_W'(old_row_lo);
    assign or1 = (old_row_hi > OLD_W'(rows_m1)) ? rows_m1 : ROW_W'(old_row_hi);

    assign new_ok = (nc0 <= nc1) && (nr0 <= nr1);
    assign old_ok = (oc0 <= oc1) && (or0 <= or1);
    assign new_after = (nr1 > or1) || ((nr1 == or1) && (nc1 > oc1));

    // The final event of a request is the bottom-right corner, in scan order,
    // of the rectangle (or the later of the two) that produces events.
    always_comb
    begin
        has_evt = 1'b0;
        lc      = nc1;
        lr      = nr1;
        case (op)
            OP_CREATE:
            begin
                has_evt = new_ok;
            end
            OP_DELETE:
            begin
                has_evt = old_ok;
                lc      = oc1;
                lr      = or1;
            end
            OP_UPDATE:
            begin
                has_evt = new_ok || old_ok;
                if (!new_ok || (old_ok && !new_after))
                begin
                    lc = oc1;
                    lr = or1;
                end
            end
            default:
            begin
                has_evt = 1'b0;
            end
        endcase
    end

    // Evaluation of the tile under the scan position.
    assign in_new = (col_reg >= nc0_reg) && (col_reg <= nc1_reg) &&
                    (row_reg >= nr0_reg) && (row_reg <= nr1_reg);
    assign in_old = (col_reg >= oc0_reg) && (col_reg <= oc1_reg) &&
                    (row_reg >= or0_reg) && (row_reg <= or1_reg);

    always_comb
    begin
        evt = 1'b0;
        act = ACT_CREATED;
        case (op_reg)
            OP_CREATE:
            begin
                evt = in_new;
            end
            OP_DELETE:
            begin
                evt = in_old;
                act = ACT_DELETED;
            end
            OP_UPDATE:
            begin
                evt = in_new || in_old;
                if (in_new && in_old)
                begin
                    act = ACT_UPDATED;
                end
                else if (in_old)
                begin
                    act = ACT_DELETED;
                end
            end
            default:
            begin
                evt = 1'b0;
            end
        endcase
    end

    assign at_last = (col_reg == last_col_reg) && (row_reg == last_row_reg);
    assign cap_hit = (cnt_reg == CAP_W'(RESULT_CAP - 1));
    assign is_last = at_last || cap_hit;
    assign load_out = cmd.advance && evt;

    assign sts.none      = !has_evt;
    assign sts.slot_free = !out_valid_reg || out_ready;
    assign sts.done_evt  = sts.slot_free && evt && is_last;

    // Scan steps row-major; the tile index simply counts along with it.
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        tile_next = tile_reg;
        cnt_next  = cnt_reg;
        if (cmd.capture)
        begin
            col_next  = '0;
            row_next  = '0;
            tile_next = '0;
            cnt_next  = '0;
        end
        else if (cmd.advance)
        begin
            tile_next = tile_reg + TILE_W'(1);
            if (evt)
            begin
                cnt_next = cnt_reg + CAP_W'(1);
            end
            if (col_reg == cols_m1_reg)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            tile_reg      <= '0;
            cnt_reg       <= '0;
            op_reg        <= OP_RESERVED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            tile_reg      <= tile_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cmd.capture)
            begin
                op_reg <= op;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            nc0_reg      <= nc0;
            nc1_reg      <= nc1;
            nr0_reg      <= nr0;
            nr1_reg      <= nr1;
            oc0_reg      <= oc0;
            oc1_reg      <= oc1;
            or0_reg      <= or0;
            or1_reg      <= or1;
            last_col_reg <= lc;
            last_row_reg <= lr;
            cols_m1_reg  <= cols_m1;
        end
        if (load_out)
        begin
            tile_index_reg <= tile_reg;
            action_reg     <= act;
            last_reg       <= is_last;
            if (op_reg == OP_DELETE)
            begin
                new_col_lo_reg <= '0;
                new_row_lo_reg <= '0;
                new_col_hi_reg <= '0;
                new_row_hi_reg <= '0;
            end
            else
            begin
                new_col_lo_reg <= STORE_W'(nc0_reg);
                new_row_lo_reg <= STORE_W'(nr0_reg);
                new_col_hi_reg <= STORE_W'(nc1_reg);
                new_row_hi_reg <= STORE_W'(nr1_reg);
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign tile_index = tile_index_reg;
    assign action     = action_reg;
    assign last       = last_reg;
    assign new_col_lo = new_col_lo_reg;
    assign new_row_lo = new_row_lo_reg;
    assign new_col_hi = new_col_hi_reg;
    assign new_row_hi = new_row_hi_reg;

endmodule

[rtl/grid_tile_rect_diff.sv]
// Top level of the grid tile rectangle diff block.
// Instantiates gtrd_cfg, gtrd_ctrl and gtrd_dp; depends on gtrd_pkg.
//
// Each request carries an operation (create, update or delete), an element's
// new bounds as Q0.16 screen fractions and the tile rectangle the element
// stored earlier. The bounds are turned into a tile rectangle in the cycle
// the request is taken (column = floor(x * cols / 65536), likewise for rows),
// and the block then walks the grid one tile per clock in row-major order
// while the output register can take a result, from tile 0 up to the last
// tile that produces an event. Every affected tile leaves as one result, in
// ascending tile index order, with last set on the final one and with the
// new rectangle attached so the element can store it (zero for a delete).
// At most 64 results leave per request. A request with no events, or with
// the reserved operation code, produces nothing and is finished in the cycle
// it is taken. A new request is taken the cycle after the previous one's
// final result has entered the output register, while that result may still
// wait to be taken.
// Column and row counts sit at byte addresses 0 and 4 of the APB-style port;
// zero acts as one and values above the grid limit saturate to it. They are
// to be changed only while the block is idle.
module grid_tile_rect_diff
    import gtrd_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Request channel.
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [OP_W-1:0]       op,
    input  logic [EDGE_W-1:0]     left_x,
    input  logic [EDGE_W-1:0]     top_y,
    input  logic [EDGE_W-1:0]     right_x,
    input  logic [EDGE_W-1:0]     bottom_y,
    input  logic [OLD_W-1:0]      old_col_lo,
    input  logic [OLD_W-1:0]      old_row_lo,
    input  logic [OLD_W-1:0]      old_col_hi,
    input  logic [OLD_W-1:0]      old_row_hi,
    // Result channel.
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [TILE_W-1:0]     tile_index,
    output logic [ACT_W-1:0]      action,
    output logic                  last,
    output logic [STORE_W-1:0]    new_col_lo,
    output logic [STORE_W-1:0]    new_row_lo,
    output logic [STORE_W-1:0]    new_col_hi,
    output logic [STORE_W-1:0]    new_row_hi
);

    logic [CFG_W-1:0] col_count;
    logic [CFG_W-1:0] row_count;
    cmd_t             cmd;
    status_t          sts;

    // Register file for the grid size.
    gtrd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .col_count (col_count),
        .row_count (row_count)
    );

    // The controller takes a request when idle and then paces the scan
    // against the output register.
    gtrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // The datapath holds both rectangles, the scan position and the result
    // register that separates the scan from the downstream consumer.
    gtrd_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .col_count  (col_count),
        .row_count  (row_count),
        .op         (op),
        .left_x     (left_x),
        .top_y      (top_y),
        .right_x    (right_x),
        .bottom_y   (bottom_y),
        .old_col_lo (old_col_lo),
        .old_row_lo (old_row_lo),
        .old_col_hi (old_col_hi),
        .old_row_hi (old_row_hi),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .tile_index (tile_index),
        .action     (action),
        .last       (last),
        .new_col_lo (new_col_lo),
        .new_row_lo (new_row_lo),
        .new_col_hi (new_col_hi),
        .new_row_hi (new_row_hi)
    );

endmodule
